// File: rtl/etb_pkg.sv
// ============================================================================
// etb_pkg - shared types for the epoch-to-BCD timestamp converter
// Pipeline depth and the control bundle passed from the stage controller.
// ============================================================================
`default_nettype none

package etb_pkg;

    // Number of register stages from input capture to the output register
    localparam int NSTAGE = 16;

    // Per-stage load enables plus the two port-side handshake signals
    typedef struct packed {
        logic [NSTAGE-1:0] load;
        logic              in_ready;
        logic              out_valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// File: rtl/epoch_ms_to_bcd_timestamp.sv
// ============================================================================
// epoch_ms_to_bcd_timestamp - UTC milliseconds to BCD calendar timestamp
// Converts milliseconds since 1970 into a packed BCD date/time record.
// ============================================================================
//
//  Channel   Dir  Port group                 Contents
//  --------  ---  -------------------------  -----------------------------------
//  input     in   s_tvalid/s_tready/s_tdata  epoch_ms [47:0]; s_tuser time_ready
//  output    out  m_tvalid/m_tready/m_tdata  bcd_timestamp [63:0]
//
//  One transaction is accepted per cycle while s_tready is high; each gives one
//  result. Each item passes through the 16 register stages, each stage holding
//  one or more constant-reciprocal multiplies and/or add/compare steps.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  A stall at the output holds only the stages that are full: bubbles close up,
//  and s_tready drops only when all 16 stages hold an item.
//
`default_nettype none

module epoch_ms_to_bcd_timestamp
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [47:0] s_tdata,   // [47:0] epoch_ms
    input  wire logic        s_tuser,   // [0] time_ready
    // output stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [63:0] m_tdata    // [63:0] bcd_timestamp
);

    // ------------------------------------------------------------------------
    // Constants. Each reciprocal is ceil(2^k / d) with k chosen so that the
    // product shifted by k gives the exact quotient over the operand's range.
    // ------------------------------------------------------------------------
    localparam logic [47:0] LAST_MS       = 48'd253402300799999;
    localparam logic [16:0] DAY_UNITS     = 17'd84375;   // ms per day / 1024
    localparam logic [29:0] DAY_RECIP     =
        30'(((64'd1 << 46) + 64'd84374) / 64'd84375);
    localparam logic [21:0] EPOCH_SHIFT   = 22'd719468;  // days 0000-03-01..1970
    localparam logic [24:0] SEC_RECIP     =
        25'(((64'd1 << 31) + 64'd124) / 64'd125);
    localparam logic [17:0] ERA_DAYS      = 18'd146097;
    localparam logic [22:0] ERA_RECIP     =
        23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    localparam logic [17:0] HOUR_RECIP    =
        18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [18:0] Q1460_RECIP   =
        19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] Q36524_RECIP  =
        19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
    localparam logic [12:0] MIN_RECIP     =
        13'(((64'd1 << 18) + 64'd59) / 64'd60);
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [18:0] YEAR_RECIP    =
        19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  C100_RECIP    =
        10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
    localparam logic [2:0]  MP_SCALE      = 3'd5;
    localparam logic [1:0]  MP_OFFSET     = 2'd2;
    localparam logic [11:0] MP_RECIP      =
        12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [3:0]  FIRST_JAN_MP  = 4'd10;       // Jan and Feb end the March year
    localparam logic [14:0] CENT_RECIP    =
        15'(((64'd1 << 21) + 64'd99) / 64'd100);
    localparam logic [6:0]  YEARS_PER_CENT = 7'd100;
    localparam logic [7:0]  TEN_RECIP     =
        8'(((64'd1 << 11) + 64'd9) / 64'd10);
    localparam logic [7:0]  PRECISE_FLAG  = 8'h01;

    // Two-digit BCD of a value below 100
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [6:0]  tens;
        logic [6:0]  units;
        prod  = v * TEN_RECIP;
        tens  = {3'd0, prod[14:11]};
        units = v - tens * 7'd10;
        return {prod[14:11], units[3:0]};
    endfunction

    // Day-of-year offset of each month, counted from March
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // ------------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------------
    etb_pkg::pipe_ctl_t ctl;

    etb_pipe_ctl u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    assign s_tready = ctl.in_ready;
    assign m_tvalid = ctl.out_valid;

    // ------------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------------
    logic        s0_zero_reg;
    logic [21:0] s0_q0_reg;
    logic [18:0] s0_xlo_reg;
    logic [9:0]  s0_msl_reg;

    logic        s1_zero_reg;
    logic [18:0] s1_r_reg;
    logic [21:0] s1_zb_reg;
    logic [9:0]  s1_msl_reg;

    logic        s2_zero_reg;
    logic [21:0] s2_z_reg;
    logic [26:0] s2_remms_reg;

    logic        s3_zero_reg;
    logic [21:0] s3_z_reg;
    logic [4:0]  s3_era_reg;
    logic [16:0] s3_sod_reg;

    logic        s4_zero_reg;
    logic [17:0] s4_doe_reg;
    logic [4:0]  s4_era_reg;
    logic [16:0] s4_sod_reg;
    logic [4:0]  s4_hour_reg;

    logic        s5_zero_reg;
    logic [17:0] s5_doe_reg;
    logic [6:0]  s5_a_reg;
    logic [2:0]  s5_b_reg;
    logic        s5_c_reg;
    logic [4:0]  s5_era_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_rs_reg;

    logic        s6_zero_reg;
    logic [17:0] s6_s_reg;
    logic [17:0] s6_doe_reg;
    logic [4:0]  s6_era_reg;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s6_min_reg;
    logic [11:0] s6_rs_reg;

    logic        s7_zero_reg;
    logic [8:0]  s7_yoe_reg;
    logic [17:0] s7_doe_reg;
    logic [4:0]  s7_era_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;
    logic [5:0]  s7_sec_reg;

    logic        s8_zero_reg;
    logic [1:0]  s8_c100_reg;
    logic [17:0] s8_base_reg;
    logic [17:0] s8_doe_reg;
    logic [13:0] s8_yb_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg;
    logic [5:0]  s8_sec_reg;

    logic        s9_zero_reg;
    logic [8:0]  s9_doy_reg;
    logic [13:0] s9_yb_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_min_reg;
    logic [5:0]  s9_sec_reg;

    logic        s10_zero_reg;
    logic [10:0] s10_t_reg;
    logic [8:0]  s10_doy_reg;
    logic [13:0] s10_yb_reg;
    logic [4:0]  s10_hour_reg;
    logic [5:0]  s10_min_reg;
    logic [5:0]  s10_sec_reg;

    logic        s11_zero_reg;
    logic [3:0]  s11_mp_reg;
    logic [8:0]  s11_doy_reg;
    logic [13:0] s11_yb_reg;
    logic [4:0]  s11_hour_reg;
    logic [5:0]  s11_min_reg;
    logic [5:0]  s11_sec_reg;

    logic        s12_zero_reg;
    logic [4:0]  s12_day_reg;
    logic [3:0]  s12_month_reg;
    logic [13:0] s12_year_reg;
    logic [4:0]  s12_hour_reg;
    logic [5:0]  s12_min_reg;
    logic [5:0]  s12_sec_reg;

    logic        s13_zero_reg;
    logic [13:0] s13_year_reg;
    logic [6:0]  s13_cent_reg;
    logic [47:0] s13_low_reg;     // month, day, flag, hour, min, sec in BCD

    logic        s14_zero_reg;
    logic [6:0]  s14_yl_reg;
    logic [6:0]  s14_cent_reg;
    logic [47:0] s14_low_reg;

    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;

    // ------------------------------------------------------------------------
    // Stage 0: days estimate from the top 32 bits of ms / 1024
    // ------------------------------------------------------------------------
    logic [61:0] day_prod;
    logic        s0_zero_next;

    assign day_prod     = s_tdata[47:16] * DAY_RECIP;
    assign s0_zero_next = !s_tuser || (s_tdata > LAST_MS);

    // Stage 1: remainder of the estimate, modulo 2^19
    logic [38:0] qd_prod;
    logic [18:0] s1_r_next;
    logic [21:0] s1_zb_next;

    assign qd_prod    = s0_q0_reg * DAY_UNITS;
    assign s1_r_next  = s0_xlo_reg - qd_prod[18:0];
    assign s1_zb_next = s0_q0_reg + EPOCH_SHIFT;

    // Stage 2: correct the estimate by one day either way
    logic        r_neg;
    logic        r_over;
    logic [18:0] rem_fix;
    logic [21:0] s2_z_next;

    assign r_neg  = s1_r_reg[18];
    assign r_over = !r_neg && (s1_r_reg >= {2'b00, DAY_UNITS});

    always_comb
    begin
        if (r_neg)
        begin
            rem_fix   = s1_r_reg + {2'b00, DAY_UNITS};
            s2_z_next = s1_zb_reg - 22'd1;
        end
        else if (r_over)
        begin
            rem_fix   = s1_r_reg - {2'b00, DAY_UNITS};
            s2_z_next = s1_zb_reg + 22'd1;
        end
        else
        begin
            rem_fix   = s1_r_reg;
            s2_z_next = s1_zb_reg;
        end
    end

    // Stage 3: 400-year era and second of day
    logic [44:0] era_prod;
    logic [48:0] sod_prod;

    assign era_prod = s2_z_reg * ERA_RECIP;
    assign sod_prod = s2_remms_reg[26:3] * SEC_RECIP;

    // Stage 4: day of era and hour
    logic [21:0] era_base;
    logic [21:0] doe_full;
    logic [34:0] hour_prod;

    assign era_base  = s3_era_reg * ERA_DAYS;
    assign doe_full  = s3_z_reg - era_base;
    assign hour_prod = s3_sod_reg * HOUR_RECIP;

    // Stage 5: leap corrections of the day of era, second within the hour
    logic [36:0] a_prod;
    logic [36:0] b_prod;
    logic [16:0] hsec;
    logic [16:0] rs_full;

    assign a_prod  = s4_doe_reg * Q1460_RECIP;
    assign b_prod  = s4_doe_reg * Q36524_RECIP;
    assign hsec    = s4_hour_reg * SEC_PER_HOUR;
    assign rs_full = s4_sod_reg - hsec;

    // Stage 6: corrected day count, minute
    logic [17:0] s6_s_next;
    logic [24:0] min_prod;

    assign s6_s_next = s5_doe_reg - {11'd0, s5_a_reg} + {15'd0, s5_b_reg}
                       - {17'd0, s5_c_reg};
    assign min_prod  = s5_rs_reg * MIN_RECIP;

    // Stage 7: year of era, second
    logic [36:0] yoe_prod;
    logic [11:0] msec;
    logic [11:0] sec_full;

    assign yoe_prod = s6_s_reg * YEAR_RECIP;
    assign msec     = s6_min_reg * SEC_PER_MIN;
    assign sec_full = s6_rs_reg - msec;

    // Stage 8: days before this year of era, base year
    logic [18:0] c100_prod;
    logic [17:0] s8_base_next;
    logic [13:0] s8_yb_next;

    assign c100_prod    = s7_yoe_reg * C100_RECIP;
    assign s8_base_next = s7_yoe_reg * DAYS_PER_YEAR + {11'd0, s7_yoe_reg[8:2]};
    assign s8_yb_next   = {5'd0, s7_yoe_reg} + s7_era_reg * YEARS_PER_ERA;

    // Stage 9: day of the March-based year
    logic [17:0] doy_full;

    assign doy_full = s8_doe_reg - s8_base_reg + {16'd0, s8_c100_reg};

    // Stage 10: month search operand
    logic [10:0] s10_t_next;

    assign s10_t_next = s9_doy_reg * MP_SCALE + MP_OFFSET;

    // Stage 11: March-based month index
    logic [22:0] mp_prod;

    assign mp_prod = s10_t_reg * MP_RECIP;

    // Stage 12: day, calendar month and year
    logic [8:0]  day_full;
    logic        jan_feb;
    logic [3:0]  s12_month_next;
    logic [13:0] s12_year_next;

    assign day_full       = s11_doy_reg - month_start(s11_mp_reg) + 9'd1;
    assign jan_feb        = s11_mp_reg >= FIRST_JAN_MP;
    assign s12_month_next = jan_feb ? s11_mp_reg - 4'd9 : s11_mp_reg + 4'd3;
    assign s12_year_next  = s11_yb_reg + {13'd0, jan_feb};

    // Stage 13: century, BCD of the low fields
    logic [28:0] cent_prod;
    logic [47:0] s13_low_next;

    assign cent_prod    = s12_year_reg * CENT_RECIP;
    assign s13_low_next = {to_bcd({3'd0, s12_month_reg}),
                           to_bcd({2'd0, s12_day_reg}),
                           PRECISE_FLAG,
                           to_bcd({2'd0, s12_hour_reg}),
                           to_bcd({1'd0, s12_min_reg}),
                           to_bcd({1'd0, s12_sec_reg})};

    // Stage 14: year within the century
    logic [13:0] yl_full;

    assign yl_full = s13_year_reg - s13_cent_reg * YEARS_PER_CENT;

    // Stage 15: assemble, drop to zero when time is not ready or out of range
    assign out_data_next = s14_zero_reg ? 64'd0 :
                           {to_bcd(s14_cent_reg), to_bcd(s14_yl_reg), s14_low_reg};

    // ------------------------------------------------------------------------
    // Payload registers: advance each stage on its load enable, hold otherwise
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s0_zero_reg <= s0_zero_next;
            s0_q0_reg   <= day_prod[61:40];
            s0_xlo_reg  <= s_tdata[28:10];
            s0_msl_reg  <= s_tdata[9:0];
        end
        if (ctl.load[1])
        begin
            s1_zero_reg <= s0_zero_reg;
            s1_r_reg    <= s1_r_next;
            s1_zb_reg   <= s1_zb_next;
            s1_msl_reg  <= s0_msl_reg;
        end
        if (ctl.load[2])
        begin
            s2_zero_reg  <= s1_zero_reg;
            s2_z_reg     <= s2_z_next;
            s2_remms_reg <= {rem_fix[16:0], s1_msl_reg};
        end
        if (ctl.load[3])
        begin
            s3_zero_reg <= s2_zero_reg;
            s3_z_reg    <= s2_z_reg;
            s3_era_reg  <= era_prod[44:40];
            s3_sod_reg  <= sod_prod[47:31];
        end
        if (ctl.load[4])
        begin
            s4_zero_reg <= s3_zero_reg;
            s4_doe_reg  <= doe_full[17:0];
            s4_era_reg  <= s3_era_reg;
            s4_sod_reg  <= s3_sod_reg;
            s4_hour_reg <= hour_prod[33:29];
        end
        if (ctl.load[5])
        begin
            s5_zero_reg <= s4_zero_reg;
            s5_doe_reg  <= s4_doe_reg;
            s5_a_reg    <= a_prod[35:29];
            s5_b_reg    <= b_prod[36:34];
            s5_c_reg    <= (s4_doe_reg == ERA_LAST_DAY);
            s5_era_reg  <= s4_era_reg;
            s5_hour_reg <= s4_hour_reg;
            s5_rs_reg   <= rs_full[11:0];
        end
        if (ctl.load[6])
        begin
            s6_zero_reg <= s5_zero_reg;
            s6_s_reg    <= s6_s_next;
            s6_doe_reg  <= s5_doe_reg;
            s6_era_reg  <= s5_era_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_min_reg  <= min_prod[23:18];
            s6_rs_reg   <= s5_rs_reg;
        end
        if (ctl.load[7])
        begin
            s7_zero_reg <= s6_zero_reg;
            s7_yoe_reg  <= yoe_prod[35:27];
            s7_doe_reg  <= s6_doe_reg;
            s7_era_reg  <= s6_era_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_min_reg  <= s6_min_reg;
            s7_sec_reg  <= sec_full[5:0];
        end
        if (ctl.load[8])
        begin
            s8_zero_reg <= s7_zero_reg;
            s8_c100_reg <= c100_prod[17:16];
            s8_base_reg <= s8_base_next;
            s8_doe_reg  <= s7_doe_reg;
            s8_yb_reg   <= s8_yb_next;
            s8_hour_reg <= s7_hour_reg;
            s8_min_reg  <= s7_min_reg;
            s8_sec_reg  <= s7_sec_reg;
        end
        if (ctl.load[9])
        begin
            s9_zero_reg <= s8_zero_reg;
            s9_doy_reg  <= doy_full[8:0];
            s9_yb_reg   <= s8_yb_reg;
            s9_hour_reg <= s8_hour_reg;
            s9_min_reg  <= s8_min_reg;
            s9_sec_reg  <= s8_sec_reg;
        end
        if (ctl.load[10])
        begin
            s10_zero_reg <= s9_zero_reg;
            s10_t_reg    <= s10_t_next;
            s10_doy_reg  <= s9_doy_reg;
            s10_yb_reg   <= s9_yb_reg;
            s10_hour_reg <= s9_hour_reg;
            s10_min_reg  <= s9_min_reg;
            s10_sec_reg  <= s9_sec_reg;
        end
        if (ctl.load[11])
        begin
            s11_zero_reg <= s10_zero_reg;
            s11_mp_reg   <= mp_prod[22:19];
            s11_doy_reg  <= s10_doy_reg;
            s11_yb_reg   <= s10_yb_reg;
            s11_hour_reg <= s10_hour_reg;
            s11_min_reg  <= s10_min_reg;
            s11_sec_reg  <= s10_sec_reg;
        end
        if (ctl.load[12])
        begin
            s12_zero_reg  <= s11_zero_reg;
            s12_day_reg   <= day_full[4:0];
            s12_month_reg <= s12_month_next;
            s12_year_reg  <= s12_year_next;
            s12_hour_reg  <= s11_hour_reg;
            s12_min_reg   <= s11_min_reg;
            s12_sec_reg   <= s11_sec_reg;
        end
        if (ctl.load[13])
        begin
            s13_zero_reg <= s12_zero_reg;
            s13_year_reg <= s12_year_reg;
            s13_cent_reg <= cent_prod[27:21];
            s13_low_reg  <= s13_low_next;
        end
        if (ctl.load[14])
        begin
            s14_zero_reg <= s13_zero_reg;
            s14_yl_reg   <= yl_full[6:0];
            s14_cent_reg <= s13_cent_reg;
            s14_low_reg  <= s13_low_reg;
        end
        if (ctl.load[15])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/etb_pipe_ctl.sv
// ============================================================================
// etb_pipe_ctl - valid tracking and stall control for the converter pipeline
// Each stage loads when it is empty or when some later stage can move.
// ============================================================================
`default_nettype none

module etb_pipe_ctl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              out_ready,
    output etb_pkg::pipe_ctl_t     ctl
);

    localparam logic [etb_pkg::NSTAGE-1:0] ALL_STAGES = '1;

    logic [etb_pkg::NSTAGE-1:0] valid_reg;
    logic [etb_pkg::NSTAGE-1:0] valid_next;
    logic [etb_pkg::NSTAGE-1:0] room;
    logic                       in_fire;
    logic                       out_fire;

    // A stage may load when the output drains or any stage at or after it is empty
    always_comb
    begin
        for (int i = 0; i < etb_pkg::NSTAGE; i++)
        begin
            room[i] = out_ready || (|(~valid_reg & (ALL_STAGES << i)));
        end
    end

    always_comb
    begin
        valid_next[0] = room[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < etb_pkg::NSTAGE; i++)
        begin
            valid_next[i] = room[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load      = room;
    assign ctl.in_ready  = room[0];
    assign ctl.out_valid = valid_reg[etb_pkg::NSTAGE-1];

    assign in_fire  = in_valid && room[0];
    assign out_fire = valid_reg[etb_pkg::NSTAGE-1] && out_ready;

    // Backpressure reaches the input only when every stage holds an item
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !room[0] |-> (&valid_reg))
        else $error("input blocked while a stage is empty");

    // Items in flight change only through the two ports
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_fire && !out_fire) |=>
            ($countones(valid_reg) == $countones($past(valid_reg))))
        else $error("item count changed without a transaction");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_fire) |=>
            ($countones(valid_reg) == $countones($past(valid_reg)) + 1))
        else $error("accepted item lost or duplicated");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_fire && out_fire) |=>
            ($countones(valid_reg) + 1 == $countones($past(valid_reg))))
        else $error("delivered item not retired");

endmodule

`default_nettype wire
